// ===== design/lpht_pkg.sv =====
// Package: shared types, constants and codes for the linear probe hash table.
`default_nettype none
package lpht_pkg;

  localparam int unsigned ADDR_BITS_DEF = 12;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERASE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZE_LOG2 = 3'd0,
    CFG_MUL_A     = 3'd1,
    CFG_MUL_B     = 3'd2,
    CFG_SHIFT     = 3'd3,
    CFG_TOMB      = 3'd4
  } cfg_idx_t;

  localparam logic [3:0]  SIZE_LOG2_RST = 4'd12;
  localparam logic [31:0] MUL_A_RST     = 32'd2146121005;
  localparam logic [31:0] MUL_B_RST     = 32'd2221713035;
  localparam logic [4:0]  SHIFT_RST     = 5'd16;
  localparam logic [31:0] TOMB_RST      = 32'hFFFF_FFFF;

  // Classified request handed from front to back.
  typedef struct packed {
    logic        reject;
    logic [1:0]  op;
    logic [31:0] key;
    logic [63:0] handle;
    logic [31:0] mix;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CLEAR,
    BK_READ,
    BK_CHECK,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_MUL_A,
    FR_MUL_B,
    FR_FINAL,
    FR_PUSH
  } fr_state_t;

endpackage
`default_nettype wire

// ===== design/lpht_front.sv =====
// Front end: accept request, reject reserved keys, compute key mix over cycles.
`default_nettype none
module lpht_front import lpht_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [31:0] in_key,
  input  wire logic [63:0] in_handle,
  input  wire logic [31:0] mul_a,
  input  wire logic [31:0] mul_b,
  input  wire logic [4:0]  shift,
  input  wire logic [31:0] tomb,
  output logic             q_push,
  output req_t             q_data,
  input  wire logic        q_full
);
  fr_state_t st_r, st_nxt;
  req_t      req_r, req_nxt;
  logic [31:0] x_r, x_nxt;
  logic [4:0]  s;

  assign s = (shift == 5'd0) ? 5'd1 : shift;
  assign in_ready = (st_r == FR_IDLE);
  assign q_push   = (st_r == FR_PUSH) && !q_full;
  assign q_data   = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    req_r <= req_nxt;
    x_r   <= x_nxt;
  end

  always_comb begin
    st_nxt  = st_r;
    req_nxt = req_r;
    x_nxt   = x_r;
    unique case (st_r)
      FR_IDLE: begin
        if (in_valid) begin
          req_nxt.op     = in_op;
          req_nxt.key    = in_key;
          req_nxt.handle = in_handle;
          req_nxt.mix    = 32'd0;
          req_nxt.reject = (in_op == OP_NONE) || (in_key == 32'd0) || (in_key == tomb);
          x_nxt  = in_key ^ (in_key >> s);
          st_nxt = FR_MUL_A;
        end
      end
      FR_MUL_A: begin
        x_nxt  = x_r * mul_a;
        x_nxt  = x_nxt ^ (x_nxt >> (s - 5'd1));
        st_nxt = FR_MUL_B;
      end
      FR_MUL_B: begin
        x_nxt  = x_r * mul_b;
        st_nxt = FR_FINAL;
      end
      FR_FINAL: begin
        req_nxt.mix = x_r ^ (x_r >> s);
        st_nxt = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_full) st_nxt = FR_IDLE;
      end
      default: st_nxt = FR_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/lpht_queue.sv =====
// Two-entry queue between front end and back end.
`default_nettype none
module lpht_queue import lpht_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output req_t      pop_data
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

// ===== design/lpht_back.sv =====
// Back end: clearing pass, slot probing, table update and result register.
`default_nettype none
module lpht_back import lpht_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  req_t             q_data,
  output logic             q_pop,
  input  wire logic [3:0]  size_log2,
  input  wire logic [31:0] tomb,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [63:0]      out_found_handle
);
  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [31:0] key_mem [DEPTH];
  logic [63:0] hdl_mem [DEPTH];

  bk_state_t st_r, st_nxt;
  req_t      req_r, req_nxt;
  logic [ADDR_BITS-1:0] idx_r, idx_nxt, free_r, free_nxt, mask;
  logic [ADDR_BITS:0]   n_r, n_nxt;
  logic                 have_free_r, have_free_nxt;
  logic [31:0] rk_r;
  logic [63:0] rh_r;
  logic        ok_r, ok_nxt, ov_r, ov_nxt;
  logic [63:0] fh_r, fh_nxt;
  logic        res_ok_r;
  logic [63:0] res_fh_r;
  logic        res_ld;
  logic        kw, hw;
  logic [ADDR_BITS-1:0] waddr;
  logic [31:0] wkey;
  logic [63:0] whdl;
  logic [3:0]  l;

  always_comb begin
    l = (size_log2 == 4'd0) ? 4'd1 : size_log2;
    if ({28'd0, l} > ADDR_BITS) l = 4'(ADDR_BITS);
    mask = ADDR_BITS'(({{ADDR_BITS{1'b0}}, 1'b1} << l) - 1'b1);
  end

  assign out_valid        = ov_r;
  assign out_ok           = res_ok_r;
  assign out_found_handle = res_fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_CLEAR;
      ov_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      idx_r <= idx_nxt;
    end
    req_r <= req_nxt;
    free_r <= free_nxt;
    n_r <= n_nxt;
    have_free_r <= have_free_nxt;
    ok_r <= ok_nxt;
    fh_r <= fh_nxt;
    // Hold the result beat apart from the working registers.
    if (res_ld) begin
      res_ok_r <= ok_r;
      res_fh_r <= fh_r;
    end
    rk_r <= key_mem[idx_r];
    rh_r <= hdl_mem[idx_r];
    if (kw) key_mem[waddr] <= wkey;
    if (hw) hdl_mem[waddr] <= whdl;
  end

  always_comb begin
    st_nxt = st_r; req_nxt = req_r; idx_nxt = idx_r; free_nxt = free_r;
    n_nxt = n_r; have_free_nxt = have_free_r; ok_nxt = ok_r; fh_nxt = fh_r;
    ov_nxt = ov_r && !out_ready;
    q_pop = 1'b0; kw = 1'b0; hw = 1'b0; res_ld = 1'b0;
    waddr = idx_r; wkey = 32'd0; whdl = 64'd0;
    unique case (st_r)
      BK_CLEAR: begin
        kw = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == {ADDR_BITS{1'b1}}) st_nxt = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          req_nxt = q_data;
          idx_nxt = q_data.mix[ADDR_BITS-1:0] & mask;
          n_nxt = '0;
          have_free_nxt = 1'b0;
          ok_nxt = 1'b0;
          fh_nxt = 64'd0;
          st_nxt = q_data.reject ? BK_DONE : BK_READ;
        end
      end
      BK_READ: st_nxt = BK_CHECK;
      BK_CHECK: begin
        st_nxt = BK_DONE;
        if (rk_r == req_r.key) begin
          if (req_r.op == OP_INSERT) begin
            hw = 1'b1; whdl = req_r.handle; ok_nxt = 1'b1;
          end else if (req_r.op == OP_LOOKUP) begin
            ok_nxt = 1'b1; fh_nxt = rh_r;
          end else if (req_r.handle == 64'd0 || rh_r == req_r.handle) begin
            hw = 1'b1; kw = 1'b1; wkey = tomb; ok_nxt = 1'b1;
          end
        end else begin
          if (req_r.op == OP_INSERT && !have_free_r &&
              (rk_r == tomb || rk_r == 32'd0)) begin
            have_free_nxt = 1'b1; free_nxt = idx_r;
          end
          if (rk_r == 32'd0 || n_r == {1'b0, mask}) begin
            if (req_r.op == OP_INSERT &&
                (have_free_r || rk_r == tomb || rk_r == 32'd0)) begin
              st_nxt = BK_WRITE;
            end
          end else begin
            idx_nxt = (idx_r + 1'b1) & mask;
            n_nxt = n_r + 1'b1;
            st_nxt = BK_READ;
          end
        end
      end
      BK_WRITE: begin
        waddr = free_r; kw = 1'b1; hw = 1'b1;
        wkey = req_r.key; whdl = req_r.handle; ok_nxt = 1'b1;
        st_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          res_ld = 1'b1;
          st_nxt = BK_IDLE;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/linear_probe_hash_table_unit.sv =====
// Top level: linear probe hash table with config registers, front end, queue, back end.
//  channel | dir | beat contents
//  in_     | in  | op, key, handle
//  out_    | out | ok, found_handle
//  cfg_    | in  | index, data (register write)
// After reset a clearing pass empties the key store; requests wait in the front end
// and the queue meanwhile. The front end mixes each key with two registered
// multiplies and takes no new request until the last one is pushed into the queue.
// The back end takes a request, reads and checks each probed slot in the BK_READ and
// BK_CHECK states (one memory read port), writes an insert into a free slot in
// BK_WRITE and loads the result register in BK_DONE. A stalled result holds the back end.
`default_nettype none
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_op,
  input  wire logic [31:0]          in_key,
  input  wire logic [63:0]          in_handle,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_ok,
  output logic [63:0]               out_found_handle,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);
  logic [3:0]  size_log2_r;
  logic [31:0] mul_a_r, mul_b_r, tomb_r;
  logic [4:0]  shift_r;

  // Config writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_log2_r <= SIZE_LOG2_RST;
      mul_a_r     <= MUL_A_RST;
      mul_b_r     <= MUL_B_RST;
      shift_r     <= SHIFT_RST;
      tomb_r      <= TOMB_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_LOG2: size_log2_r <= cfg_data[3:0];
        CFG_MUL_A:     mul_a_r     <= cfg_data;
        CFG_MUL_B:     mul_b_r     <= cfg_data;
        CFG_SHIFT:     shift_r     <= cfg_data[4:0];
        CFG_TOMB:      tomb_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic q_push, q_full, q_pop, q_empty;
  req_t q_in, q_out;

  lpht_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_key, .in_handle,
    .mul_a(mul_a_r), .mul_b(mul_b_r), .shift(shift_r), .tomb(tomb_r),
    .q_push, .q_data(q_in), .q_full
  );

  lpht_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  lpht_back #(.ADDR_BITS(ADDR_BITS)) u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop,
    .size_log2(size_log2_r), .tomb(tomb_r),
    .out_valid, .out_ready, .out_ok, .out_found_handle
  );
endmodule
`default_nettype wire

// ===== design/lpht_checker.sv =====
// Checker: port-level assertions on the hash table unit, with bind.
`default_nettype none
module lpht_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_ok,
  input wire logic [63:0] out_found_handle
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found_handle) && $stable(out_ok))
    else $error("result beat changed while stalled");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_found_handle == 64'd0)
    else $error("failed request carries a handle");
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("front end took two beats back to back");
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind linear_probe_hash_table_unit lpht_checker u_lpht_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_ok, .out_found_handle
);
`default_nettype wire
